### design/ikrp_pkg.sv
// Shared types and constants for the item kNN rating predictor.
`default_nettype none

package ikrp_pkg;

   localparam int SIM_W      = 16;
   localparam int VAL_W      = 16;
   localparam int PRED_W     = 18;
   localparam int NC_W       = 7;
   localparam int DEV_W      = VAL_W + 1;
   localparam int PROD_W     = SIM_W + DEV_W;
   localparam int QBITS      = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_MEAN    = 1'b1;

   localparam logic [NC_W-1:0]  NEIGHBOR_COUNT_RST = 7'd10;
   localparam logic [VAL_W-1:0] GLOBAL_MEAN_RST    = 16'd0;

   typedef struct packed {
      logic signed [SIM_W-1:0] similarity;
      logic [VAL_W-1:0]        rating;
      logic [VAL_W-1:0]        item_mean;
      logic                    is_target;
      logic                    last_item;
   } req_type;

   typedef struct packed {
      logic signed [PRED_W-1:0] prediction;
      logic                     used_fallback;
      logic [NC_W-1:0]          neighbors_used;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SIM_W-1:0] sim;
      logic [VAL_W-1:0]        rating;
      logic [VAL_W-1:0]        mean;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_OUT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic signed [SIM_W-1:0] new_sim;
      logic [VAL_W-1:0]        new_rating;
      logic [VAL_W-1:0]        new_mean;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DRAIN,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### design/item_knn_rating_predict_unit.sv
// Top level: item-based kNN mean-centered rating prediction unit.
//
//   channel   dir   handshake               beat payload
//   req       in    req_valid / req_ready   req_type: one catalog item
//   rsp       out   rsp_valid / rsp_ready   rsp_type: one prediction per query
//   csr       in    csr_we                  csr_index, csr_wdata
//
// Ordinary items are accepted while the FSM idles: the systolic list of
// MAX_NEIGHBORS cells inserts a beat at the edge it is accepted.
// After the last item of a query the FSM passes a setup state, drains the
// used neighbors through the multiply-accumulate, runs the divider (skipped
// on fallback) and then loads the output register.
// Reset is synchronous; it empties the list and loads the register defaults.
// The result waits in the output register; a new query streams in meanwhile,
// and only its last beat's result waits for the register to be taken.
`default_nettype none

module item_knn_rating_predict_unit
   import ikrp_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FILL_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int CMP_W  = (FILL_W > NC_W) ? FILL_W : NC_W;
   localparam int ACC_W  = PROD_W + FILL_W;
   localparam int WS_W   = (SIM_W - 1) + FILL_W;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_NEIGHBORS);
   localparam logic [CMP_W-1:0]  K_MAX    = CMP_W'(MAX_NEIGHBORS);

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [NC_W-1:0]   nc_ff;
   logic [VAL_W-1:0]  gm_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [VAL_W-1:0]  tm_ff;
   logic [NC_W-1:0]   used_ff;
   logic [NC_W-1:0]   drain_cnt_ff;
   logic              pv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SIM_W-1:0]  psim_ff;
   logic signed [ACC_W-1:0]  sum_ff;
   logic [WS_W-1:0]   ws_ff;
   logic              neg_ff;
   logic              fb_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // ---------------------------------------------------------------- control
   logic          req_fire;
   logic          ins;
   cell_op_type   cell_op;
   cell_ctrl_type cell_ctrl;
   logic          drain_step;
   logic          finish_drain;
   logic          div_start;
   logic          div_done;
   logic          load_rsp;
   logic [QBITS-1:0] quotient;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // rated, positively similar, not the target
   assign ins = req_fire && !req_data.is_target && (req_data.rating != '0)
                && !req_data.similarity[SIM_W-1] && (req_data.similarity != '0);

   assign cell_ctrl.op         = cell_op;
   assign cell_ctrl.new_sim    = req_data.similarity;
   assign cell_ctrl.new_rating = req_data.rating;
   assign cell_ctrl.new_mean   = req_data.item_mean;

   // ---------------------------------------------------------------- cell chain
   entry_type             cell_q    [MAX_NEIGHBORS];
   logic [MAX_NEIGHBORS-1:0] cell_less;
   logic [MAX_NEIGHBORS-1:0] cell_valid;

   for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_l;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_l = 1'b0;
      end else begin : g_inner
         assign left_e = cell_q[i-1];
         assign left_l = cell_less[i-1];
      end

      if (i == MAX_NEIGHBORS - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_body
         assign right_e = cell_q[i+1];
      end

      ikrp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .left_entry  (left_e),
         .left_less   (left_l),
         .right_entry (right_e),
         .entry       (cell_q[i]),
         .less        (cell_less[i])
      );

      assign cell_valid[i] = cell_q[i].valid;
   end

   // ---------------------------------------------------------------- k and used
   logic [CMP_W-1:0] k_ext, k_sat, fill_ext, used_ext;

   assign k_ext    = CMP_W'(nc_ff);
   assign k_sat    = (k_ext > K_MAX) ? K_MAX : k_ext;
   assign fill_ext = CMP_W'(fill_ff);
   assign used_ext = (fill_ext < k_sat) ? fill_ext : k_sat;

   // ---------------------------------------------------------------- MAC front
   // head cell streams out during drain; one product per cycle
   logic signed [DEV_W-1:0]  dev;
   logic signed [PROD_W-1:0] prod_in;

   assign dev     = $signed({1'b0, cell_q[0].rating}) - $signed({1'b0, cell_q[0].mean});
   assign prod_in = cell_q[0].sim * dev;

   // ---------------------------------------------------------------- divider
   logic [ACC_W-1:0] sum_mag;

   assign sum_mag = sum_ff[ACC_W-1] ? ACC_W'(-sum_ff) : ACC_W'(sum_ff);

   ikrp_divider #(
      .DIV_W (ACC_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (ACC_W'(ws_ff)),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------- FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cell_op      = CELL_HOLD;
      drain_step   = 1'b0;
      finish_drain = 1'b0;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ins) begin
               cell_op = CELL_INSERT;
            end
            if (req_fire && req_data.last_item) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_cnt_ff != '0) begin
               cell_op    = CELL_SHIFT_OUT;
               drain_step = 1'b1;
            end else if (!pv_ff) begin
               // sums are final; empty the list for the next query
               cell_op      = CELL_CLEAR;
               finish_drain = 1'b1;
               if (ws_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- result
   logic [PRED_W-1:0] q_ext, q_signed, pred;

   assign q_ext    = PRED_W'(quotient);
   assign q_signed = neg_ff ? (~q_ext + 1'b1) : q_ext;
   assign pred     = fb_ff ? PRED_W'(gm_ff) : (PRED_W'(tm_ff) + q_signed);

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff        <= NEIGHBOR_COUNT_RST;
         gm_ff        <= GLOBAL_MEAN_RST;
         fill_ff      <= '0;
         tm_ff        <= '0;
         drain_cnt_ff <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_NEIGHBOR_COUNT: nc_ff <= csr_wdata[NC_W-1:0];
               CSR_GLOBAL_MEAN:    gm_ff <= csr_wdata[VAL_W-1:0];
               default:            nc_ff <= nc_ff;
            endcase
         end

         if (req_fire && req_data.is_target) begin
            tm_ff <= req_data.item_mean;
         end
         if (ins && (fill_ff != FILL_MAX)) begin
            fill_ff <= fill_ff + 1'b1;
         end

         if (state_ff == ST_SETUP) begin
            drain_cnt_ff <= used_ext[NC_W-1:0];
         end else if (drain_step) begin
            drain_cnt_ff <= drain_cnt_ff - 1'b1;
         end
         pv_ff <= drain_step;

         if (finish_drain) begin
            fill_ff <= '0;
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            tm_ff        <= '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      psim_ff <= cell_q[0].sim;
      if (state_ff == ST_SETUP) begin
         used_ff <= used_ext[NC_W-1:0];
         sum_ff  <= '0;
         ws_ff   <= '0;
      end else if (pv_ff) begin
         sum_ff <= sum_ff + ACC_W'(prod_ff);
         ws_ff  <= ws_ff + WS_W'(psim_ff[SIM_W-2:0]);
      end
      if (finish_drain) begin
         neg_ff <= sum_ff[ACC_W-1];
         fb_ff  <= (ws_ff == '0);
      end
      if (load_rsp) begin
         rsp_ff.prediction     <= pred;
         rsp_ff.used_fallback  <= fb_ff;
         rsp_ff.neighbors_used <= fb_ff ? '0 : used_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- assertions
   // occupied cells always match the fill count outside the drain
   a_fill_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DRAIN) |-> ($countones(cell_valid) == 32'(fill_ff)))
      else $error("list occupancy differs from fill count");

   // occupied cells form a prefix and stay sorted by falling similarity
   for (genvar j = 0; j < MAX_NEIGHBORS - 1; j++) begin : g_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         cell_q[j+1].valid |-> (cell_q[j].valid && (cell_q[j].sim >= cell_q[j+1].sim)))
         else $error("neighbor list out of order");
   end

   // the last beat of a query closes the input until its result is formed
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.last_item) |=> !req_ready)
      else $error("input open right after last beat");

   // the divider only finishes while the FSM waits for it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

endmodule

`default_nettype wire

### design/ikrp_cell.sv
// One slot of the sorted neighbor list; trades entries with its neighbors.
`default_nettype none

module ikrp_cell
   import ikrp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     left_entry,
   input  wire logic          left_less,
   input  wire entry_type     right_entry,
   output entry_type          entry,
   output logic               less
);

   entry_type entry_ff;
   entry_type entry_in;

   // new item ranks above this slot (ties stay ahead of the new item)
   assign less  = !entry_ff.valid || (entry_ff.sim < ctrl.new_sim);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (less && !left_less) begin
               entry_in.valid  = 1'b1;
               entry_in.sim    = ctrl.new_sim;
               entry_in.rating = ctrl.new_rating;
               entry_in.mean   = ctrl.new_mean;
            end else if (less) begin
               entry_in = left_entry;
            end
         end
         CELL_SHIFT_OUT: begin
            entry_in = right_entry;
         end
         CELL_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.sim    <= entry_in.sim;
      entry_ff.rating <= entry_in.rating;
      entry_ff.mean   <= entry_in.mean;
   end

endmodule

`default_nettype wire

### design/ikrp_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module ikrp_divider
   import ikrp_pkg::*;
#(
   parameter int DIV_W = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic [QBITS-1:0]      quotient
);

   localparam int CNT_W = $clog2(QBITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dsh_ff;
   logic [QBITS-1:0] q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             fits;

   assign fits     = rem_ff >= dsh_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_LAST;
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= divisor << (QBITS - 1);
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[QBITS-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

endmodule

`default_nettype wire

### bench/ikrp_prediction_checker.sv
// Checker for the kNN rating predictor: watches all three channels, predicts results, compares them.
module ikrp_prediction_checker
   import ikrp_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_total,
   output int                         predictions_open
);

   // neighbor list sorted by falling similarity, ties keep arrival order
   int kept_sim    [MAX_NEIGHBORS];
   int kept_rating [MAX_NEIGHBORS];
   int kept_mean   [MAX_NEIGHBORS];
   int kept_fill;
   int target_mean;
   int k_setting;
   int fallback_mean;

   rsp_type predictions_due [$];

   function automatic void forget_query();
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         kept_sim[i]    = 0;
         kept_rating[i] = 0;
         kept_mean[i]   = 0;
      end
      kept_fill   = 0;
      target_mean = 0;
   endfunction

   always @(posedge clock) begin
      rsp_type seen, want, made;
      int      sim_value, slot, k_eff, used;
      longint  weighted_dev, weight_sum;
      if (reset) begin
         forget_query();
         k_setting     = NEIGHBOR_COUNT_RST;
         fallback_mean = GLOBAL_MEAN_RST;
         predictions_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = rsp_data;
            if (predictions_due.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %p", $time, seen);
               mismatch_total++;
            end else begin
               want = predictions_due.pop_front();
               if (seen.prediction !== want.prediction) begin
                  $display("%0t prediction: expected %0d, actual %0d",
                           $time, want.prediction, seen.prediction);
                  mismatch_total++;
               end
               if (seen.used_fallback !== want.used_fallback) begin
                  $display("%0t used_fallback: expected %0b, actual %0b",
                           $time, want.used_fallback, seen.used_fallback);
                  mismatch_total++;
               end
               if (seen.neighbors_used !== want.neighbors_used) begin
                  $display("%0t neighbors_used: expected %0d, actual %0d",
                           $time, want.neighbors_used, seen.neighbors_used);
                  mismatch_total++;
               end
            end
         end

         if (req_valid && req_ready) begin
            sim_value = req_data.similarity;
            if (req_data.is_target) begin
               target_mean = req_data.item_mean;
            end else if (req_data.rating != 0 && sim_value > 0) begin
               slot = 0;
               while (slot < kept_fill && kept_sim[slot] >= sim_value)
                  slot++;
               if (slot < MAX_NEIGHBORS) begin
                  if (kept_fill < MAX_NEIGHBORS)
                     kept_fill++;
                  for (int i = kept_fill - 1; i > slot; i--) begin
                     kept_sim[i]    = kept_sim[i-1];
                     kept_rating[i] = kept_rating[i-1];
                     kept_mean[i]   = kept_mean[i-1];
                  end
                  kept_sim[slot]    = sim_value;
                  kept_rating[slot] = req_data.rating;
                  kept_mean[slot]   = req_data.item_mean;
               end
            end

            if (req_data.last_item) begin
               k_eff = (k_setting > MAX_NEIGHBORS) ? MAX_NEIGHBORS : k_setting;
               used  = (kept_fill < k_eff) ? kept_fill : k_eff;
               weighted_dev = 0;
               weight_sum   = 0;
               for (int i = 0; i < used; i++) begin
                  weighted_dev += longint'(kept_sim[i]) *
                                  longint'(kept_rating[i] - kept_mean[i]);
                  weight_sum   += longint'(kept_sim[i]);
               end
               if (weight_sum > 0) begin
                  made.prediction     = PRED_W'(longint'(target_mean) +
                                                weighted_dev / weight_sum);
                  made.used_fallback  = 1'b0;
                  made.neighbors_used = NC_W'(used);
               end else begin
                  made.prediction     = PRED_W'(fallback_mean);
                  made.used_fallback  = 1'b1;
                  made.neighbors_used = '0;
               end
               predictions_due.push_back(made);
               forget_query();
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_NEIGHBOR_COUNT: k_setting = csr_wdata[NC_W-1:0];
               CSR_GLOBAL_MEAN:    fallback_mean = csr_wdata;
               default: ;
            endcase
         end
      end
      predictions_open = predictions_due.size();
   end

endmodule

### bench/item_knn_rating_predict_unit_test.sv
// Stimulus and verdict for the item kNN rating predictor bench.
module item_knn_rating_predict_unit_test;
   import ikrp_pkg::*;

   localparam int STALL_LIMIT   = 5000;  // cycles without any beat before giving up
   localparam int SETTLE_CYCLES = 120;   // covers drain of 64 neighbors + divider + output
   localparam int ITEM_GOAL     = 1200;
   localparam int PHASES        = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_total;
   int predictions_open;
   int items_sent  = 0;
   int quiet_cycles = 0;
   bit idle_on     = 1'b1;

   // k per random phase: extremes first (1, max, zero, saturating), then ordinary ones
   int k_plan [0:PHASES-1] = '{1, 64, 0, 127, 7, 10, 33, 3};

   item_knn_rating_predict_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ikrp_prediction_checker prediction_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_total   (mismatch_total),
      .predictions_open (predictions_open)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stall bursts while idling is on, else always ready.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic req_type pack_item(input logic [SIM_W-1:0] sim,
                                         input logic [VAL_W-1:0] rating,
                                         input logic [VAL_W-1:0] mean,
                                         input bit target, input bit last);
      req_type item;
      item.similarity = sim;
      item.rating     = rating;
      item.item_mean  = mean;
      item.is_target  = target;
      item.last_item  = last;
      return item;
   endfunction

   // Mostly qualifying neighbors; the rest are targets, unrated items,
   // non-positive similarities and raw noise.
   function automatic req_type make_item(input bit last);
      req_type item;
      int      pick;
      item = req_type'($bits(req_type)'({$urandom, $urandom}));
      pick = $urandom_range(0, 99);
      item.is_target = 1'b0;
      if (pick < 60) begin
         // shifted 0x7FFF gives a short list of values, so ties show up often
         if ($urandom_range(0, 2) == 0)
            item.similarity = SIM_W'(32767 >> $urandom_range(0, 14));
         else
            item.similarity = SIM_W'($urandom_range(1, 32767));
         item.rating = VAL_W'($urandom_range(1, 65535));
         if ($urandom_range(0, 1) == 0)
            item.item_mean = VAL_W'(item.rating + $urandom_range(0, 1023) - 512);
      end else if (pick < 70) begin
         item.is_target = 1'b1;
      end else if (pick < 80) begin
         item.rating = '0;
      end else if (pick < 90) begin
         item.similarity = SIM_W'(-int'($urandom_range(0, 32768)));
      end else begin
         item.is_target = 1'($urandom_range(0, 1));
      end
      item.last_item = last;
      return item;
   endfunction

   // Presents one beat and holds it until accepted; returns on a falling edge
   // with valid dropped, so a following beat can take its place at once.
   task automatic send_item(input req_type item);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      items_sent++;
   endtask

   // Register writes only once every query has come back and the block is quiet.
   task automatic write_settings(input logic [NC_W-1:0] k, input logic [VAL_W-1:0] fallback);
      wait (predictions_open == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_NEIGHBOR_COUNT;
      csr_wdata = CSR_DATA_W'(k);
      @(negedge clock);
      csr_index = CSR_GLOBAL_MEAN;
      csr_wdata = fallback;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   initial begin
      int span;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_NEIGHBOR_COUNT;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // out-of-range query: lone last beat, no neighbors, reset global mean
      send_item(pack_item(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));

      write_settings(7'd2, 16'hFFFF);
      // equal similarity: earlier beat keeps its place, k=2 cuts after it;
      // the target carries qualifying fields but must stay out of the list;
      // the last beat itself qualifies and ranks first
      send_item(pack_item(16'h7FFF, 16'h0500, 16'h0200, 1'b1, 1'b0));
      send_item(pack_item(16'h2000, 16'h0300, 16'h0100, 1'b0, 1'b0));
      send_item(pack_item(16'h2000, 16'h0100, 16'h0400, 1'b0, 1'b0));
      send_item(pack_item(16'h2000, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
      send_item(pack_item(16'h7FFF, 16'h0001, 16'h0000, 1'b0, 1'b1));
      // two targets (latest mean wins), deepest negative deviation
      send_item(pack_item(16'h0001, 16'h0200, 16'h1000, 1'b1, 1'b0));
      send_item(pack_item(16'h0001, 16'h0001, 16'hFFFF, 1'b0, 1'b0));
      send_item(pack_item(16'h4000, 16'h0300, 16'h0050, 1'b1, 1'b0));
      send_item(pack_item(16'h7FFF, 16'h0001, 16'hFFFF, 1'b0, 1'b0));
      send_item(pack_item(16'h7FFF, 16'h0000, 16'h1234, 1'b0, 1'b1));
      // no target at all; non-positive similarities are skipped
      send_item(pack_item(16'h8000, 16'h0100, 16'h0000, 1'b0, 1'b0));
      send_item(pack_item(16'h0000, 16'h0100, 16'h0000, 1'b0, 1'b0));
      send_item(pack_item(16'hFFFF, 16'h0100, 16'h0000, 1'b0, 1'b0));
      send_item(pack_item(16'h0100, 16'h0300, 16'h0100, 1'b0, 1'b1));
      // nothing qualifies -> fallback of 0xFFFF; last beat is a target
      send_item(pack_item(16'h1234, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
      send_item(pack_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));

      write_settings(7'd0, 16'h8000);
      // k of zero: a good neighbor is present but the fallback comes out
      send_item(pack_item(16'h7FFF, 16'h0400, 16'h0200, 1'b0, 1'b1));

      // --- random part: one register setting per phase, last phase without idling ---
      for (int phase = 0; phase < PHASES; phase++) begin
         write_settings(NC_W'(k_plan[phase]),
                        (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'h0000
                                                                : VAL_W'($urandom));
         idle_on = (phase != PHASES - 1);
         while (items_sent < ITEM_GOAL * (phase + 1) / PHASES) begin
            // a few queries hold more items than the 64-entry list has cells, most stay short
            if ($urandom_range(0, 19) == 0)
               span = $urandom_range(65, 100);
            else
               span = $urandom_range(1, 16);
            for (int i = 1; i <= span; i++)
               send_item(make_item(i == span));
         end
      end
      req_valid = 1'b0;

      wait (predictions_open == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_total == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
design/ikrp_pkg.sv
design/ikrp_cell.sv
design/ikrp_divider.sv
design/item_knn_rating_predict_unit.sv
bench/ikrp_prediction_checker.sv
bench/item_knn_rating_predict_unit_test.sv
